### rtl/ase_pkg.sv
// Shared types and constants for the array sort engine.
// Used by ase_cell and array_sort_engine; depends on nothing else.
package ase_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int DEFAULT_DEPTH = 64;
  localparam int ADDR_WIDTH    = 2;
  localparam int CFG_WIDTH     = 32;

  typedef logic signed [DATA_WIDTH-1:0] value_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] element_value;
    logic                         final_element;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         end_of_set;
    logic                         overflow_flag;
  } out_item_t;

  // Commands broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic drain_asc;
    logic drain_desc;
  } ase_ctl_t;

endpackage

### rtl/ase_cell.sv
// One cell of the sorting chain: holds one element and its valid bit.
// Depends on ase_pkg for the value and command types.
module ase_cell
  import ase_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ase_ctl_t ctl,
  input  value_t   new_value,
  input  value_t   left_value,
  input  logic     left_valid,
  input  logic     left_gt,
  input  value_t   right_value,
  input  logic     right_valid,
  output value_t   value_o,
  output logic     valid_o,
  output logic     gt_o,
  output value_t   top_value_o
);

  value_t value_r, value_nxt;
  logic   valid_r, valid_nxt;
  logic   gt;
  logic   is_top;

  // An empty cell behaves as positive infinity, so the chain stays ascending
  // with all empty cells above the held elements.
  assign gt     = !valid_r || (value_r > new_value);
  assign is_top = valid_r && !right_valid;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.insert) begin
      if (gt) begin
        value_nxt = left_gt ? left_value : new_value;
        valid_nxt = left_gt ? left_valid : 1'b1;
      end
    end else if (ctl.drain_asc) begin
      value_nxt = right_value;
      valid_nxt = right_valid;
    end else if (ctl.drain_desc) begin
      valid_nxt = valid_r && right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o     = value_r;
  assign valid_o     = valid_r;
  assign gt_o        = gt;
  assign top_value_o = is_top ? value_r : '0;

endmodule

### rtl/array_sort_engine.sv
// Array sort engine: an insertion chain of DEPTH cells keeps elements in order as they arrive.
// One element is accepted per cycle while busy is low; the closing transaction starts a burst of n results,
// registered through state_r and then out_data_r, one per cycle; busy is high while the burst drains.
// Results cannot be stalled. Reset empties the chain, clears the count and the drop mark,
// and selects ascending order. Depends on ase_pkg and ase_cell.
module array_sort_engine
  import ase_pkg::*;
#(
  parameter int DEPTH = DEFAULT_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_WIDTH-1:0]  pwdata,
  output logic [CFG_WIDTH-1:0]  prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  typedef enum logic {S_IDLE, S_DRAIN} state_t;

  state_t           state_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] remaining_r;
  logic             dropped_r;
  logic             desc_cfg_r;
  logic             desc_r;
  logic             ovf_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  ase_ctl_t ctl;
  logic     accept;
  logic     full;
  logic     cfg_write;
  value_t   top_value;

  value_t cell_value [DEPTH];
  logic   cell_valid [DEPTH];
  logic   cell_gt    [DEPTH];
  value_t cell_top   [DEPTH];

  assign busy      = (state_r == S_DRAIN);
  assign accept    = start && !busy;
  assign full      = (count_r == FULL_COUNT);
  assign cfg_write = psel && penable && pwrite;

  assign ctl.insert     = accept && !full;
  assign ctl.drain_asc  = busy && !desc_r;
  assign ctl.drain_desc = busy && desc_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t lval, rval;
    logic   lvalid, lgt, rvalid;

    if (i == 0) begin : g_first
      assign lval   = in_data.element_value;
      assign lvalid = 1'b1;
      assign lgt    = 1'b0;
    end else begin : g_mid
      assign lval   = cell_value[i-1];
      assign lvalid = cell_valid[i-1];
      assign lgt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rval   = '0;
      assign rvalid = 1'b0;
    end else begin : g_inner
      assign rval   = cell_value[i+1];
      assign rvalid = cell_valid[i+1];
    end

    ase_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_value   (in_data.element_value),
      .left_value  (lval),
      .left_valid  (lvalid),
      .left_gt     (lgt),
      .right_value (rval),
      .right_valid (rvalid),
      .value_o     (cell_value[i]),
      .valid_o     (cell_valid[i]),
      .gt_o        (cell_gt[i]),
      .top_value_o (cell_top[i])
    );
  end

  // At most one cell is the highest held element; the others contribute zero.
  always_comb begin
    top_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      top_value = top_value | cell_top[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      remaining_r <= '0;
      dropped_r   <= 1'b0;
      desc_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      out_valid_r              <= 1'b0;
      out_data_r.sorted_value  <= desc_r ? top_value : cell_value[0];
      out_data_r.end_of_set    <= (remaining_r == CNT_W'(1));
      out_data_r.overflow_flag <= ovf_r;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (!full) begin
              count_r <= count_r + CNT_W'(1);
            end else begin
              dropped_r <= 1'b1;
            end
            if (in_data.final_element) begin
              state_r     <= S_DRAIN;
              remaining_r <= full ? count_r : count_r + CNT_W'(1);
              desc_r      <= desc_cfg_r;
              ovf_r       <= dropped_r || full;
            end
          end
        end
        S_DRAIN: begin
          out_valid_r <= 1'b1;
          remaining_r <= remaining_r - CNT_W'(1);
          if (remaining_r == CNT_W'(1)) begin
            state_r   <= S_IDLE;
            count_r   <= '0;
            dropped_r <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Every address decodes to the single direction register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desc_cfg_r <= 1'b0;
    end else if (cfg_write) begin
      desc_cfg_r <= pwdata[0];
    end
  end

  assign prdata    = {{(CFG_WIDTH-1){1'b0}}, desc_cfg_r};
  assign pready    = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic unused_addr;
  assign unused_addr = ^paddr;

endmodule

### test/array_sort_engine_test.sv
// Self-checking testbench for array_sort_engine: sets of signed elements are driven in,
// and every sorted burst is checked against a local insertion-sort predictor.
// Depends on ase_pkg and the array_sort_engine RTL only.
`timescale 1ns / 1ps

module array_sort_engine_test;
  import ase_pkg::*;

  localparam int SET_CAPACITY = DEFAULT_DEPTH;
  localparam int RANDOM_ITEMS_PER_PHASE = 10;
  localparam int DRAIN_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [ADDR_WIDTH-1:0] SORT_ORDER_ADDR = '0;
  localparam value_t MOST_NEGATIVE = 32'sh8000_0000;
  localparam value_t MOST_POSITIVE = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [CFG_WIDTH-1:0] pwdata = '0;
  logic [CFG_WIDTH-1:0] prdata;
  logic pready;

  // Elements waiting to be offered, and sorted results still to arrive.
  in_item_t pending_items[$];
  out_item_t expected_results[$];

  // Predictor copy of the block's state and its sort order register.
  value_t held_values[SET_CAPACITY];
  int held_count = 0;
  bit held_dropped = 1'b0;
  bit descending_order = 1'b0;

  int send_gap_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit offer_next;
  out_item_t oldest_expected;
  value_t last_value = '0;

  array_sort_engine dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Stores one accepted element; a closing element sorts the held set and
  // queues one expected result per held element.
  task automatic predict_sorted_burst(input in_item_t item);
    out_item_t res;
    value_t key;
    int i;
    int j;
    if (held_count < SET_CAPACITY) begin
      held_values[held_count] = item.element_value;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (item.final_element) begin
      for (i = 1; i < held_count; i++) begin
        key = held_values[i];
        j = i;
        while (j > 0 && (descending_order ? (held_values[j-1] < key)
                                          : (held_values[j-1] > key))) begin
          held_values[j] = held_values[j-1];
          j--;
        end
        held_values[j] = key;
      end
      for (i = 0; i < held_count; i++) begin
        res.sorted_value = held_values[i];
        res.end_of_set = (i == held_count - 1);
        res.overflow_flag = held_dropped;
        expected_results.push_back(res);
      end
      held_count = 0;
      held_dropped = 1'b0;
    end
  endtask

  // Driver: a transaction is taken at an edge with start high and busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_sorted_burst(pending_items.pop_front());
        offer_next = 1'b1;
      end else begin
        offer_next = !start;
      end
      if (offer_next) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          start <= 1'b1;
          in_data <= pending_items[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d", out_data.sorted_value));
      end else begin
        oldest_expected = expected_results.pop_front();
        if (out_data.sorted_value !== oldest_expected.sorted_value)
          report_mismatch($sformatf("sorted_value got %0d want %0d",
                                    out_data.sorted_value, oldest_expected.sorted_value));
        if (out_data.end_of_set !== oldest_expected.end_of_set)
          report_mismatch($sformatf("end_of_set got %b want %b",
                                    out_data.end_of_set, oldest_expected.end_of_set));
        if (out_data.overflow_flag !== oldest_expected.overflow_flag)
          report_mismatch($sformatf("overflow_flag got %b want %b",
                                    out_data.overflow_flag, oldest_expected.overflow_flag));
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("array_sort_engine_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_sort_order(input logic [CFG_WIDTH-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SORT_ORDER_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    descending_order = value[0];
  endtask

  task automatic queue_element(input value_t value, input bit last);
    in_item_t item;
    item.element_value = value;
    item.final_element = last;
    pending_items.push_back(item);
  endtask

  // Mostly full-range values, with small values and repeats to produce ties.
  function automatic value_t random_value();
    value_t v;
    case ($urandom_range(0, 9))
      6, 7: v = value_t'($urandom_range(0, 8)) - 4;
      8: v = $urandom_range(0, 1) ? MOST_POSITIVE : MOST_NEGATIVE;
      9: v = last_value;
      default: v = $urandom;
    endcase
    last_value = v;
    return v;
  endfunction

  task automatic queue_random_set(input int size);
    int k;
    for (k = 0; k < size; k++) queue_element(random_value(), k == size - 1);
  endtask

  // Waits until every element has been sent and every expected result has arrived, then
  // lets the block settle before anything else happens.
  task automatic wait_for_drain();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int gap_pct, input bit write_cfg,
                           input logic [CFG_WIDTH-1:0] cfg_value, input int extra_set);
    int queued;
    int size;
    if (write_cfg) write_sort_order(cfg_value);
    @(negedge clk);
    send_gap_pct = gap_pct;
    if (extra_set != 0) queue_random_set(extra_set);
    queued = 0;
    while (queued < RANDOM_ITEMS_PER_PHASE) begin
      size = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 12);
      queue_random_set(size);
      queued += size;
    end
    wait_for_drain();
  endtask

  task automatic queue_extremes_set();
    queue_element(MOST_POSITIVE, 1'b0);
    queue_element(MOST_NEGATIVE, 1'b0);
    queue_element(0, 1'b0);
    queue_element(-1, 1'b0);
    queue_element(1, 1'b0);
    queue_element(MOST_NEGATIVE, 1'b0);
    queue_element(MOST_POSITIVE, 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sets in the reset order (ascending): extremes, a lone element, ties.
    @(negedge clk);
    send_gap_pct = 28;
    queue_extremes_set();
    queue_element(32'sd12345, 1'b1);
    queue_element(5, 1'b0);
    queue_element(5, 1'b0);
    queue_element(5, 1'b1);
    wait_for_drain();
    write_sort_order(32'h0000_0001);
    @(negedge clk);
    queue_extremes_set();
    wait_for_drain();

    // Random phases; one holds exactly a full store, one overflows it and
    // drops the closing element too.
    run_phase(28, 1'b1, 32'h0000_0000, 0);
    run_phase(28, 1'b1, 32'h0000_0001, SET_CAPACITY);
    run_phase(81, 1'b1, 32'hffff_fffe, 0);
    run_phase(81, 1'b1, 32'hffff_ffff, SET_CAPACITY + 3);
    run_phase(0, 1'b1, 32'h0000_0000, 0);
    run_phase(0, 1'b1, 32'h0000_0001, 0);

    if (mismatch_count == 0) begin
      $display("array_sort_engine_test OK");
    end else begin
      $display("array_sort_engine_test NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/ase_pkg.sv
rtl/ase_cell.sv
rtl/array_sort_engine.sv
test/array_sort_engine_test.sv
